[src/wllc_pkg.sv]
// ----------------------------------------------------------------------------
// wllc_pkg
// Shared types, constants and helpers for the windowed lead-lag correlator.
// ----------------------------------------------------------------------------
package wllc_pkg;

  // Defaults for top-level parameters
  localparam int DEF_WINDOW_DEPTH  = 256;
  localparam int DEF_MAX_LAG_LIMIT = 16;
  localparam int DEF_SAMPLE_BITS   = 16;

  // Fixed field widths
  localparam int WIDE_W     = 64;  // width of sums and long arithmetic
  localparam int CORR_W     = 16;  // Q1.15 correlation
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int HL_W       = 9;
  localparam int RW_W       = 9;
  localparam int ML_W       = 5;

  localparam int MIN_PAIRS   = 3;
  localparam int VALID_PAIRS = 10;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HISTORY_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROLLING_WINDOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LAG        = 2'd2;

  // Register reset values
  localparam logic [HL_W-1:0] HL_RESET = 9'd256;
  localparam logic [RW_W-1:0] RW_RESET = 9'd64;
  localparam logic [ML_W-1:0] ML_RESET = 5'd5;

  // Variance normalization bound (2^30)
  localparam logic [WIDE_W-1:0] NORM_BOUND = 64'h0000_0000_4000_0000;

  localparam logic signed [CORR_W-1:0] CORR_MAX = 16'sh7fff;
  localparam logic signed [CORR_W-1:0] CORR_MIN = 16'sh8000;

  // Shared math unit
  typedef enum logic [1:0] {
    MOP_MUL,
    MOP_SQRT,
    MOP_DIV
  } math_op_t;

  typedef struct packed {
    logic     start;
    math_op_t op;
  } math_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } math_rsp_t;

  // Sequencer
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SPAN,
    ST_RD,
    ST_M0,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_VX1,
    ST_VX2,
    ST_VY1,
    ST_VY2,
    ST_C1,
    ST_C2,
    ST_CHK,
    ST_NORM,
    ST_PROD,
    ST_SQRT,
    ST_DIV,
    ST_STORE,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    SPAN_FULL,
    SPAN_ROLL,
    SPAN_LAG
  } span_t;

  // Magnitude of a Q1.15 value, one bit wider so -1.0 fits
  function automatic logic [CORR_W:0] corr_mag(input logic signed [CORR_W-1:0] v);
    logic signed [CORR_W:0] e;
    e = {v[CORR_W-1], v};
    return v[CORR_W-1] ? (CORR_W+1)'(-e) : (CORR_W+1)'(e);
  endfunction

endpackage

[src/windowed_lead_lag_correlation.sv]
// ----------------------------------------------------------------------------
// windowed_lead_lag_correlation
// Pearson correlation of two return series over full history, a rolling
// window and a range of lags, with a search for the strongest lag.
// ----------------------------------------------------------------------------
//  channel  | direction | content
//  s_*      | in        | tdata: x_return, y_return
//  m_*      | out       | tdata: full_corr, rolling_corr, best_lag, lag_coeff;
//           |           | tuser: valid_res
//  cfg_*    | in        | write of history_limit, rolling_window, max_lag
//
// One request at a time: each span of len pairs is accumulated pair by pair
// and then goes through the shared multiply/root/divide unit; with
// 10 or more pairs a request covers 2 spans, plus 2*max_lag+1 lag spans once
// max_lag+3 pairs are held. With fewer than 10 pairs no span is computed.
// Reset is synchronous; history contents are left as they are.
// s_tready is high only when the sequencer is idle; a finished result waits
// in the output register while the next request is taken.
module windowed_lead_lag_correlation import wllc_pkg::*; #(
  parameter int WINDOW_DEPTH  = DEF_WINDOW_DEPTH,
  parameter int MAX_LAG_LIMIT = DEF_MAX_LAG_LIMIT,
  parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS,
  localparam int MAG_W = $clog2(MAX_LAG_LIMIT + 1),
  localparam int LAG_W = MAG_W + 1,
  localparam int IN_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8,
  localparam int RES_W = 3 * CORR_W + LAG_W,
  localparam int OUT_W = ((RES_W + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_W-1:0]       s_tdata,   // x_return, y_return
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_W-1:0]      m_tdata,   // full_corr, rolling_corr, best_lag, lag_coeff
  output logic                  m_tuser,   // valid_res
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ADDR_W = $clog2(WINDOW_DEPTH);
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int PTR_W  = CNT_W + 1;
  localparam int PROD_W = 2 * SAMPLE_BITS;

  // Configuration
  logic [HL_W-1:0] hist_limit;
  logic [RW_W-1:0] roll_win;
  logic [ML_W-1:0] max_lag;

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_limit <= HL_RESET;
      roll_win   <= RW_RESET;
      max_lag    <= ML_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_HISTORY_LIMIT:  hist_limit <= HL_W'(cfg_data);
        REG_ROLLING_WINDOW: roll_win   <= RW_W'(cfg_data);
        REG_MAX_LAG:        max_lag    <= cfg_data[ML_W-1:0];
        default: ;
      endcase
    end
  end

  // History memory
  logic signed [SAMPLE_BITS-1:0] x_mem [WINDOW_DEPTH];
  logic signed [SAMPLE_BITS-1:0] y_mem [WINDOW_DEPTH];
  logic signed [SAMPLE_BITS-1:0] xd;
  logic signed [SAMPLE_BITS-1:0] yd;
  logic [ADDR_W-1:0]             wslot;
  logic [ADDR_W-1:0]             xptr;
  logic [ADDR_W-1:0]             yptr;
  logic                          accept;

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (accept) begin
      x_mem[wslot] <= s_tdata[SAMPLE_BITS-1:0];
      y_mem[wslot] <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    end
    xd <= x_mem[xptr];
    yd <= y_mem[yptr];
  end

  // Sequencer and datapath registers
  state_t state;
  state_t state_next;
  span_t  kind;

  logic [CNT_W-1:0]              n;
  logic [CNT_W-1:0]              span_len;
  logic [CNT_W-1:0]              idx;
  logic [MAG_W-1:0]              lag_max;
  logic signed [LAG_W-1:0]       lag;
  logic signed [WIDE_W-1:0]      sx, sy, sxx, syy, sxy;
  logic signed [PROD_W-1:0]      prod;
  logic signed [WIDE_W-1:0]      t1, vx, vy, cc;
  logic [WIDE_W-1:0]             ux, uy, mm, pp, dd;
  logic signed [CORR_W-1:0]      r;
  logic                          ok;
  logic                          mbusy;
  logic signed [CORR_W-1:0]      held_full, held_roll, held_coeff;
  logic signed [LAG_W-1:0]       held_lag;
  logic                          res_valid;
  logic [RES_W-1:0]              out_data;
  logic                          out_valid;

  // Derived values
  logic [CNT_W-1:0]  limit;
  logic [CNT_W:0]    n_plus;
  logic [CNT_W-1:0]  n_new;
  logic [MAG_W-1:0]  lag_lim;
  logic              lag_en;
  logic [MAG_W-1:0]  lag_abs;
  logic [CNT_W-1:0]  len_c, xoff_c, yoff_c, nr_c;
  logic [PTR_W-1:0]  base_c, xs_c, ys_c;
  logic              step_x, step_y;
  logic [WIDE_W-1:0] q_res;
  logic signed [CORR_W-1:0] q_sat;
  logic              out_free;

  always_comb begin
    if (32'(hist_limit) < 32'(MIN_PAIRS))          limit = CNT_W'(MIN_PAIRS);
    else if (32'(hist_limit) > 32'(WINDOW_DEPTH))  limit = CNT_W'(WINDOW_DEPTH);
    else                                           limit = CNT_W'(hist_limit);
    n_plus = {1'b0, n} + 1'b1;
    n_new  = (n_plus > {1'b0, limit}) ? limit : CNT_W'(n_plus);
    lag_lim = (32'(max_lag) > 32'(MAX_LAG_LIMIT)) ? MAG_W'(MAX_LAG_LIMIT) : MAG_W'(max_lag);
    lag_en  = 32'(n) >= 32'(lag_max) + 32'(MIN_PAIRS);
    lag_abs = lag[LAG_W-1] ? MAG_W'(-lag) : MAG_W'(lag);
    nr_c    = (32'(roll_win) < 32'(n)) ? CNT_W'(roll_win) : n;

    // span geometry
    case (kind)
      SPAN_ROLL: begin
        len_c  = nr_c;
        xoff_c = n - nr_c;
        yoff_c = n - nr_c;
      end
      SPAN_LAG: begin
        len_c  = n - CNT_W'(lag_abs);
        xoff_c = lag[LAG_W-1] ? CNT_W'(lag_abs) : '0;
        yoff_c = lag[LAG_W-1] ? '0 : CNT_W'(lag_abs);
      end
      default: begin
        len_c  = n;
        xoff_c = '0;
        yoff_c = '0;
      end
    endcase

    // oldest held pair sits n slots behind the write slot
    if (PTR_W'(wslot) >= PTR_W'(n)) base_c = PTR_W'(wslot) - PTR_W'(n);
    else base_c = PTR_W'(wslot) + PTR_W'(WINDOW_DEPTH) - PTR_W'(n);
    xs_c = base_c + PTR_W'(xoff_c);
    ys_c = base_c + PTR_W'(yoff_c);
    if (xs_c >= PTR_W'(WINDOW_DEPTH)) xs_c = xs_c - PTR_W'(WINDOW_DEPTH);
    if (ys_c >= PTR_W'(WINDOW_DEPTH)) ys_c = ys_c - PTR_W'(WINDOW_DEPTH);

    step_x = ux >= NORM_BOUND;
    step_y = uy >= NORM_BOUND;
    out_free = !out_valid || m_tready;
  end

  // Shared math unit
  math_req_t         mreq;
  math_rsp_t         mrsp;
  logic [WIDE_W-1:0] ma, mb, mres;
  logic              math_state;

  always_comb begin
    math_state = 1'b0;
    ma = '0;
    mb = '0;
    mreq.op = MOP_MUL;
    case (state)
      ST_VX1:  begin math_state = 1'b1; ma = sxx; mb = WIDE_W'(span_len); end
      ST_VX2:  begin math_state = 1'b1; ma = sx;  mb = sx; end
      ST_VY1:  begin math_state = 1'b1; ma = syy; mb = WIDE_W'(span_len); end
      ST_VY2:  begin math_state = 1'b1; ma = sy;  mb = sy; end
      ST_C1:   begin math_state = 1'b1; ma = sxy; mb = WIDE_W'(span_len); end
      ST_C2:   begin math_state = 1'b1; ma = sx;  mb = sy; end
      ST_PROD: begin math_state = 1'b1; ma = ux;  mb = uy; end
      ST_SQRT: begin math_state = 1'b1; ma = pp; mreq.op = MOP_SQRT; end
      ST_DIV: begin
        math_state = dd != '0;
        ma = (mm << CORR_W) + dd;
        mb = dd << 1;
        mreq.op = MOP_DIV;
      end
      default: ;
    endcase
    mreq.start = math_state && !mbusy && !mrsp.busy;
  end

  wllc_math u_math (
    .clk    (clk),
    .rst    (rst),
    .req    (mreq),
    .opnd_a (ma),
    .opnd_b (mb),
    .rsp    (mrsp),
    .result (mres)
  );

  // Quotient to saturated Q1.15 with the sign of the covariance
  always_comb begin
    q_res = mres;
    if (!cc[WIDE_W-1]) begin
      q_sat = (q_res >= WIDE_W'(32767)) ? CORR_MAX : CORR_W'(q_res);
    end else begin
      q_sat = (q_res >= WIDE_W'(32768)) ? CORR_MIN : -CORR_W'(q_res);
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (s_tvalid) state_next = (32'(n_new) >= 32'(VALID_PAIRS)) ? ST_SPAN : ST_DONE;
      ST_SPAN:  state_next = (32'(len_c) < 32'(MIN_PAIRS)) ? ST_STORE : ST_RD;
      ST_RD:    state_next = ST_M0;
      ST_M0:    state_next = ST_M1;
      ST_M1:    state_next = ST_M2;
      ST_M2:    state_next = ST_M3;
      ST_M3:    state_next = (idx + 1'b1 == span_len) ? ST_VX1 : ST_RD;
      ST_VX1:   if (mrsp.done) state_next = ST_VX2;
      ST_VX2:   if (mrsp.done) state_next = ST_VY1;
      ST_VY1:   if (mrsp.done) state_next = ST_VY2;
      ST_VY2:   if (mrsp.done) state_next = ST_C1;
      ST_C1:    if (mrsp.done) state_next = ST_C2;
      ST_C2:    if (mrsp.done) state_next = ST_CHK;
      ST_CHK:   state_next = (vx <= 0 || vy <= 0) ? ST_STORE : ST_NORM;
      ST_NORM:  if (!step_x && !step_y) state_next = ST_PROD;
      ST_PROD:  if (mrsp.done) state_next = ST_SQRT;
      ST_SQRT:  if (mrsp.done) state_next = ST_DIV;
      ST_DIV:   if (dd == '0 || mrsp.done) state_next = ST_STORE;
      ST_STORE: begin
        case (kind)
          SPAN_FULL: state_next = ST_SPAN;
          SPAN_ROLL: state_next = lag_en ? ST_SPAN : ST_DONE;
          default:   state_next = (lag == LAG_W'(lag_max)) ? ST_DONE : ST_SPAN;
        endcase
      end
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      n          <= '0;
      wslot      <= '0;
      held_full  <= '0;
      held_roll  <= '0;
      held_lag   <= '0;
      held_coeff <= '0;
      res_valid  <= 1'b0;
      out_valid  <= 1'b0;
      mbusy      <= 1'b0;
      kind       <= SPAN_FULL;
      lag        <= '0;
      lag_max    <= '0;
    end else begin
      // output register: load when done, clear once taken
      if (state == ST_DONE && out_free) out_valid <= 1'b1;
      else if (m_tready)                out_valid <= 1'b0;
      if (mreq.start) mbusy <= 1'b1;
      if (mrsp.done)  mbusy <= 1'b0;

      case (state)
        ST_IDLE: if (s_tvalid) begin
          wslot     <= (wslot == ADDR_W'(WINDOW_DEPTH - 1)) ? '0 : wslot + 1'b1;
          n         <= n_new;
          res_valid <= 32'(n_new) >= 32'(VALID_PAIRS);
          kind      <= SPAN_FULL;
          lag_max   <= lag_lim;
          if (32'(n_new) >= 32'(VALID_PAIRS)) begin
            held_lag   <= '0;
            held_coeff <= '0;
          end
        end
        ST_STORE: begin
          case (kind)
            SPAN_FULL: begin
              held_full <= r;
              kind      <= SPAN_ROLL;
            end
            SPAN_ROLL: begin
              held_roll <= r;
              kind      <= SPAN_LAG;
              lag       <= -$signed({1'b0, lag_max});
            end
            default: begin
              if (ok && corr_mag(r) > corr_mag(held_coeff)) begin
                held_coeff <= r;
                held_lag   <= lag;
              end
              lag <= lag + 1'b1;
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_SPAN: begin
        span_len <= len_c;
        idx      <= '0;
        xptr     <= ADDR_W'(xs_c);
        yptr     <= ADDR_W'(ys_c);
        sx  <= '0;
        sy  <= '0;
        sxx <= '0;
        syy <= '0;
        sxy <= '0;
        r   <= '0;
        ok  <= 1'b0;
      end
      ST_M0: begin
        sx   <= sx + WIDE_W'(xd);
        sy   <= sy + WIDE_W'(yd);
        prod <= xd * xd;
      end
      ST_M1: begin
        sxx  <= sxx + WIDE_W'(prod);
        prod <= yd * yd;
      end
      ST_M2: begin
        syy  <= syy + WIDE_W'(prod);
        prod <= xd * yd;
      end
      ST_M3: begin
        sxy  <= sxy + WIDE_W'(prod);
        idx  <= idx + 1'b1;
        xptr <= (xptr == ADDR_W'(WINDOW_DEPTH - 1)) ? '0 : xptr + 1'b1;
        yptr <= (yptr == ADDR_W'(WINDOW_DEPTH - 1)) ? '0 : yptr + 1'b1;
      end
      ST_VX1, ST_VY1, ST_C1: if (mrsp.done) t1 <= mres;
      ST_VX2: if (mrsp.done) vx <= t1 - mres;
      ST_VY2: if (mrsp.done) vy <= t1 - mres;
      ST_C2:  if (mrsp.done) cc <= t1 - mres;
      ST_CHK: begin
        ux <= vx;
        uy <= vy;
        mm <= cc[WIDE_W-1] ? -cc : cc;
      end
      // scale variances below 2^30 two bits a step, covariance follows one bit per step
      ST_NORM: begin
        if (step_x) ux <= ux >> 2;
        if (step_y) uy <= uy >> 2;
        mm <= mm >> ({1'b0, step_x} + {1'b0, step_y});
      end
      ST_PROD: if (mrsp.done) pp <= mres;
      ST_SQRT: if (mrsp.done) dd <= mres;
      ST_DIV: if (mrsp.done) begin
        r  <= q_sat;
        ok <= 1'b1;
      end
      ST_DONE: if (out_free) begin
        out_data <= {held_coeff, held_lag, held_roll, held_full};
        m_tuser  <= res_valid;
      end
      default: ;
    endcase
  end

  assign s_tready = state == ST_IDLE;
  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_W'(out_data);

endmodule

[src/wllc_math.sv]
// ----------------------------------------------------------------------------
// wllc_math
// Shared iterative unit: shift-add multiply, bitwise square root and
// restoring divide, one step per cycle.
// ----------------------------------------------------------------------------
module wllc_math import wllc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  math_req_t         req,
  input  logic [WIDE_W-1:0] opnd_a,
  input  logic [WIDE_W-1:0] opnd_b,
  output math_rsp_t         rsp,
  output logic [WIDE_W-1:0] result
);

  localparam int CNT_W = $clog2(WIDE_W + 1);

  logic              busy;
  logic              done;
  math_op_t          op;
  logic [WIDE_W-1:0] acc;
  logic [WIDE_W-1:0] ra;
  logic [WIDE_W-1:0] rb;
  logic [CNT_W-1:0]  cnt;
  logic              neg;

  logic [WIDE_W-1:0] abs_a;
  logic [WIDE_W-1:0] abs_b;
  logic [WIDE_W-1:0] root_try;
  logic [WIDE_W:0]   div_sh;
  logic              div_ge;

  assign abs_a    = opnd_a[WIDE_W-1] ? -opnd_a : opnd_a;
  assign abs_b    = opnd_b[WIDE_W-1] ? -opnd_b : opnd_b;
  assign root_try = acc + rb;
  assign div_sh   = {acc, ra[WIDE_W-1]};
  assign div_ge   = div_sh >= {1'b0, rb};

  assign rsp.busy = busy;
  assign rsp.done = done;

  // Step engine
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op   <= req.op;
        acc  <= '0;
        case (req.op)
          MOP_MUL: begin
            ra  <= abs_a;
            rb  <= abs_b;
            neg <= opnd_a[WIDE_W-1] ^ opnd_b[WIDE_W-1];
          end
          MOP_SQRT: begin
            ra <= opnd_a;
            rb <= WIDE_W'(1) << (WIDE_W - 2);
          end
          MOP_DIV: begin
            ra  <= opnd_a;
            rb  <= opnd_b;
            cnt <= CNT_W'(WIDE_W);
          end
          default: ;
        endcase
      end else if (busy) begin
        case (op)
          // multiply: stops as soon as the multiplier runs out of ones
          MOP_MUL: begin
            if (rb == '0) begin
              result <= neg ? -acc : acc;
              busy   <= 1'b0;
              done   <= 1'b1;
            end else begin
              if (rb[0]) acc <= acc + ra;
              ra <= ra << 1;
              rb <= rb >> 1;
            end
          end
          // integer square root, two radicand bits a step
          MOP_SQRT: begin
            if (rb == '0) begin
              result <= acc;
              busy   <= 1'b0;
              done   <= 1'b1;
            end else begin
              if (ra >= root_try) begin
                ra  <= ra - root_try;
                acc <= (acc >> 1) + rb;
              end else begin
                acc <= acc >> 1;
              end
              rb <= rb >> 2;
            end
          end
          // restoring divide, quotient shifts into ra
          MOP_DIV: begin
            if (cnt == '0) begin
              result <= ra;
              busy   <= 1'b0;
              done   <= 1'b1;
            end else begin
              if (div_ge) acc <= WIDE_W'(div_sh - {1'b0, rb});
              else        acc <= WIDE_W'(div_sh);
              ra  <= {ra[WIDE_W-2:0], div_ge};
              cnt <= cnt - 1'b1;
            end
          end
          default: busy <= 1'b0;
        endcase
      end
    end
  end

endmodule

[tb/tb_windowed_lead_lag_correlation.sv]
// ----------------------------------------------------------------------------
// tb_windowed_lead_lag_correlation
// Streams return pairs through the lead-lag correlator under several register
// settings, predicts results with a bit-exact model of the correlation and lag
// search (typed rows give theirs directly), and compares each result field by field.
// ----------------------------------------------------------------------------
module tb_windowed_lead_lag_correlation;
  import wllc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH   = 256;
  localparam int LAG_LIM = 16;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    bit                 typed;  // expected result given directly
  } pair_req_t;

  typedef struct {
    logic signed [15:0] full_c;
    logic signed [15:0] roll_c;
    logic signed [5:0]  lag;
    logic signed [15:0] coeff;
    logic               valid;
  } corr_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        m_tuser;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  windowed_lead_lag_correlation uut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready,
    .m_tdata, .m_tuser, .cfg_we, .cfg_addr, .cfg_data
  );

  always #10 clk = ~clk;

  // predictor state
  int          hx [DEPTH];
  int          hy [DEPTH];
  int          held_cnt, wr_slot;
  corr_res_t   held = '{0, 0, 0, 0, 1'b0};
  logic [8:0]  m_hist_lim = HL_RESET;
  logic [8:0]  m_roll_win = RW_RESET;
  logic [4:0]  m_max_lag  = ML_RESET;

  pair_req_t   pair_q [$];
  corr_res_t   corr_q [$];
  bit          failed = 1'b0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Pearson correlation of x[xo+i] with y[yo+i], indexes from the oldest pair
  function automatic logic signed [15:0] pearson(int n, int xo, int yo, int len,
                                                 output bit ok);
    longint sx, sy, sxx, syy, sxy, a, b, vx, vy, c;
    longint unsigned ux, uy, m, d, q;
    int ex, ey;
    ok = 0;
    sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0; ex = 0; ey = 0;
    if (len < MIN_PAIRS) return 0;
    for (int i = 0; i < len; i++) begin
      a = longint'(hx[(wr_slot + 2 * DEPTH - n + xo + i) % DEPTH]);
      b = longint'(hy[(wr_slot + 2 * DEPTH - n + yo + i) % DEPTH]);
      sx += a; sy += b; sxx += a * a; syy += b * b; sxy += a * b;
    end
    vx = len * sxx - sx * sx;
    vy = len * syy - sy * sy;
    c  = len * sxy - sx * sy;
    if (vx <= 0 || vy <= 0) return 0;
    ux = vx; uy = vy;
    while ((ux >> (2 * ex)) >= (64'h1 << 30)) ex++;
    while ((uy >> (2 * ey)) >= (64'h1 << 30)) ey++;
    ux >>= 2 * ex; uy >>= 2 * ey;
    m = (c < 0) ? -c : c;
    m >>= (ex + ey);
    d = int_sqrt(ux * uy);
    if (d == 0) return 0;
    q = (m * 65536 + d) / (2 * d);
    ok = 1;
    if (c < 0) return (q >= 32768) ? -16'sd32768 : -$signed(16'(q));
    return (q >= 32767) ? 16'sd32767 : $signed(16'(q));
  endfunction

  // append one pair and work out the result it produces
  function automatic corr_res_t predict_pair(logic signed [15:0] x, logic signed [15:0] y);
    int lim, nr, lmax, a, mag, bmag;
    bit ok;
    logic signed [15:0] r, best;
    corr_res_t res;
    lim = int'(m_hist_lim);
    if (lim < MIN_PAIRS) lim = MIN_PAIRS;
    if (lim > DEPTH) lim = DEPTH;
    hx[wr_slot] = int'(x);
    hy[wr_slot] = int'(y);
    wr_slot = (wr_slot + 1) % DEPTH;
    held_cnt++;
    if (held_cnt > lim) held_cnt = lim;
    if (held_cnt >= VALID_PAIRS) begin
      held.full_c = pearson(held_cnt, 0, 0, held_cnt, ok);
      nr = (int'(m_roll_win) < held_cnt) ? int'(m_roll_win) : held_cnt;
      held.roll_c = pearson(held_cnt, held_cnt - nr, held_cnt - nr, nr, ok);
      lmax = (int'(m_max_lag) > LAG_LIM) ? LAG_LIM : int'(m_max_lag);
      best = 0; bmag = 0; held.lag = 0;
      if (held_cnt >= lmax + MIN_PAIRS) begin
        for (int lag = -lmax; lag <= lmax; lag++) begin
          a = (lag < 0) ? -lag : lag;
          r = pearson(held_cnt, (lag < 0) ? a : 0, (lag < 0) ? 0 : a, held_cnt - a, ok);
          if (ok) begin
            mag = (r < 0) ? -int'(r) : int'(r);
            if (mag > bmag) begin
              bmag = mag; best = r; held.lag = 6'(lag);
            end
          end
        end
      end
      held.coeff = best;
    end
    res = held;
    res.valid = (held_cnt >= VALID_PAIRS);
    return res;
  endfunction

  // sender: bursts with random gaps; prediction taken at acceptance
  pair_req_t cur_pair;
  int        burst_left = 1, gap_left = 0;
  bit        nxt_valid;
  bit        offer_open = 1'b0;
  corr_res_t pred;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        pred = predict_pair(cur_pair.x, cur_pair.y);
        if (cur_pair.typed) pred = '{0, 0, 0, 0, 1'b0};
        corr_q.insert(corr_q.size(), pred);
        offer_open = 1'b0;
      end
      nxt_valid = s_tvalid && !s_tready;
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pair_q.size() > 0) begin
          cur_pair = pair_q[0];
          pair_q.delete(0);
          offer_open = 1'b1;
          s_tdata <= {cur_pair.y, cur_pair.x};
          nxt_valid = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 10);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      s_tvalid <= nxt_valid;
    end
  end

  // receiver: stall pattern in phases, plus a long hold-off on request
  int        hold_ask = 0, hold_left = 0, pat_cnt = 0, pat_mode = 0;
  corr_res_t want;
  corr_res_t got;

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.full_c = m_tdata[15:0];
        got.roll_c = m_tdata[31:16];
        got.lag    = m_tdata[37:32];
        got.coeff  = m_tdata[53:38];
        got.valid  = m_tuser;
        if (corr_q.size() == 0) begin
          $error("result with no request outstanding");
          failed = 1'b1;
        end else begin
          want = corr_q[0];
          corr_q.delete(0);
          if (got.full_c !== want.full_c) begin
            $error("full_corr exp %0d got %0d", want.full_c, got.full_c); failed = 1'b1;
          end
          if (got.roll_c !== want.roll_c) begin
            $error("rolling_corr exp %0d got %0d", want.roll_c, got.roll_c); failed = 1'b1;
          end
          if (got.lag !== want.lag) begin
            $error("best_lag exp %0d got %0d", want.lag, got.lag); failed = 1'b1;
          end
          if (got.coeff !== want.coeff) begin
            $error("lag_coeff exp %0d got %0d", want.coeff, got.coeff); failed = 1'b1;
          end
          if (got.valid !== want.valid) begin
            $error("valid_res exp %0d got %0d", want.valid, got.valid); failed = 1'b1;
          end
        end
      end
      if (hold_ask > 0) begin
        hold_left = hold_ask;
        hold_ask = 0;
      end
      pat_cnt++;
      if (pat_cnt >= 300) begin
        pat_cnt = 0;
        pat_mode = $urandom_range(0, 2);
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (pat_mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 3) != 0);
          default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // wait until every request has produced its result
  task automatic drain();
    while (pair_q.size() != 0 || offer_open || corr_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_regs(logic [8:0] hl, logic [8:0] rw, logic [4:0] ml);
    drain();
    @(posedge clk);
    cfg_we <= 1'b1; cfg_addr <= REG_HISTORY_LIMIT; cfg_data <= hl;
    @(posedge clk);
    cfg_addr <= REG_ROLLING_WINDOW; cfg_data <= rw;
    @(posedge clk);
    cfg_addr <= REG_MAX_LAG; cfg_data <= 9'(ml);
    @(posedge clk);
    cfg_we <= 1'b0;
    m_hist_lim = hl; m_roll_win = rw; m_max_lag = ml;
  endtask

  // random pairs: lead/lag related series mostly, some noise and flat runs
  logic signed [15:0] past_x [32] = '{default: '0};
  task automatic queue_random(int cnt);
    pair_req_t p;
    int k, kind;
    k = $urandom_range(0, 16);
    kind = $urandom_range(0, 9);
    for (int i = 0; i < cnt; i++) begin
      if (i % 12 == 11) begin
        k = $urandom_range(0, 16);
        kind = $urandom_range(0, 9);
      end
      p.typed = 0;
      p.x = 16'($urandom);
      if (kind == 9) p.x = 16'sd1234;
      else if ($urandom_range(0, 7) == 0) p.x = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      for (int j = 31; j > 0; j--) past_x[j] = past_x[j-1];
      past_x[0] = p.x;
      case (kind)
        0, 1, 2: p.y = past_x[k] + 16'($signed($urandom_range(0, 600)) - 300);
        3, 4:    p.y = -past_x[k];
        5:       p.y = p.x;
        6:       p.y = 16'sd0 - 16'sd7;
        default: p.y = 16'($urandom);
      endcase
      pair_q.insert(pair_q.size(), p);
    end
  endtask

  // directed rows; the first nine give zero results with valid_res low
  localparam logic signed [15:0] DIR_X [20] = '{
    16'sh7fff, 16'sh8000, 0, -1, 1, 16'sh7fff, 16'sh8000, 100, 0, 16'sh7fff,
    16'sh8000, 16'sh7fff, 5, -5, 16'sh5555, 16'shaaaa, 300, -300, 1, 0};
  localparam logic signed [15:0] DIR_Y [20] = '{
    16'sh7fff, 16'sh8000, 0, 1, -1, 16'sh8000, 16'sh7fff, 200, 16'sh8000, 0,
    16'sh7fff, 16'sh8000, 5, -5, 16'shaaaa, 16'sh5555, 16'sh7fff, 16'sh8000, -1, 0};

  pair_req_t dp;

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings, directed table
    for (int i = 0; i < 20; i++) begin
      dp.x = DIR_X[i]; dp.y = DIR_Y[i]; dp.typed = (i < 9);
      pair_q.insert(pair_q.size(), dp);
    end
    queue_random(10);
    drain();

    // smallest history and window, no lag search width
    set_regs(9'd3, 9'd3, 5'd0);
    queue_random(12);

    // lag search needs more pairs than held for a few requests
    set_regs(9'd12, 9'd9, 5'd9);
    queue_random(14);

    // widest lag, full-size window over a modest history
    set_regs(9'd40, 9'd256, 5'd16);
    queue_random(24);
    // long output hold-off while requests keep coming
    hold_ask = 40000;
    queue_random(10);

    // out-of-range settings clamp in the block
    set_regs(9'd300, 9'd0, 5'd31);
    queue_random(8);

    // lowering the limit drops the oldest pairs
    set_regs(9'd20, 9'd10, 5'd3);
    queue_random(20);
    drain();

    if (!failed) begin
      $display("tb_windowed_lead_lag_correlation: done, clean");
    end else begin
      $display("tb_windowed_lead_lag_correlation: done, errors");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("tb_windowed_lead_lag_correlation: done, errors");
    $finish;
  end

endmodule
